/* hdl/wrip_pkg.sv */
`timescale 1ns / 1ps
// Shared sizes, operation codes, status codes and state encoding for the
// weighted random index picker. No dependencies.
package wrip_pkg;

   localparam int MAX_ENTRIES  = 64;
   localparam int WEIGHT_BITS  = 16;
   localparam int RAND_BITS    = 32;

   localparam int IDX_BITS     = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS     = $clog2(MAX_ENTRIES + 1);
   localparam int TOTAL_BITS   = WEIGHT_BITS + IDX_BITS;
   localparam int DIV_CNT_BITS = $clog2(RAND_BITS);

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_PICK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_TOTAL = 2'd1,
      ST_FULL       = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DIV      = 5'b00010,
      S_SRCH_RD  = 5'b00100,
      S_SRCH_CMP = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

endpackage

/* hdl/weighted_random_index_picker_core.sv */
`timescale 1ns / 1ps
// Weighted random index picker: prefix-sum table in a synchronous RAM,
// bit-serial modulo and binary search. Depends on wrip_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one transaction: an op
//   (clear, append weight, pick index), a weight and a 32-bit random word.
//   Response channel (rsp_valid / rsp_stall) returns exactly one transaction
//   per request: picked index, status and the entry count after the op.
//   Clear and append go to the done state, which loads the output register
//   once it is free; the next request is taken back in idle. A pick runs a
//   restoring modulo of the random word by the running total, one bit per
//   cycle, then a binary search over the prefix-sum RAM, each step a RAM read
//   state and a compare state, for ceil(log2(count)) steps plus a final check.
//   One transaction is in flight at a time; req_stall is high while it runs.
//   A finished response sits in the output register; the block keeps taking
//   a new request meanwhile, and holds its next result until rsp_stall drops.
//   Synchronous reset empties the table (count and total to zero) and drops
//   any pending response; the RAM contents are left as they are.
module weighted_random_index_picker_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_op,
   input  logic [15:0]                        req_weight,
   input  logic [wrip_pkg::RAND_BITS-1:0]     req_random_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [wrip_pkg::IDX_BITS-1:0]      rsp_index,
   output logic [1:0]                         rsp_status,
   output logic [wrip_pkg::CNT_BITS-1:0]      rsp_entry_count
);

   localparam int TB = wrip_pkg::TOTAL_BITS;
   localparam int IB = wrip_pkg::IDX_BITS;
   localparam int CB = wrip_pkg::CNT_BITS;
   localparam int RB = wrip_pkg::RAND_BITS;
   localparam int DB = wrip_pkg::DIV_CNT_BITS;

   // Prefix-sum table, one write port (append) and one registered read (search)
   logic [TB-1:0] mem [wrip_pkg::MAX_ENTRIES];
   logic          mem_we;
   logic [IB-1:0] rd_addr;
   logic [TB-1:0] rd_data_ff;

   wrip_pkg::state_type  state_ff, state_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [TB-1:0]        total_ff, total_in;
   logic [TB-1:0]        rem_ff, rem_in;
   logic [RB-1:0]        rnd_ff, rnd_in;
   logic [DB-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [IB-1:0]        lo_ff, lo_in;
   logic [IB-1:0]        hi_ff, hi_in;
   logic [IB-1:0]        res_index_ff, res_index_in;
   wrip_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IB-1:0]        rsp_index_ff, rsp_index_in;
   wrip_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [CB-1:0]        rsp_count_ff, rsp_count_in;

   logic [TB-1:0]        append_sum;
   logic [TB:0]          rem_shift;
   logic [TB-1:0]        rem_next;
   logic [IB:0]          mid_sum;
   logic [IB-1:0]        mid;
   logic                 out_free;

   assign req_stall       = (state_ff != wrip_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Output slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Only the low WEIGHT_BITS of the weight count toward the total
   assign append_sum = total_ff + TB'(req_weight[wrip_pkg::WEIGHT_BITS-1:0]);

   // One restoring step of the modulo: shift in the next random bit,
   // subtract the total when the partial remainder reaches it
   assign rem_shift = {rem_ff, rnd_ff[RB-1]};
   always_comb begin
      if (rem_shift >= {1'b0, total_ff}) begin
         rem_next = TB'(rem_shift - {1'b0, total_ff});
      end else begin
         rem_next = rem_shift[TB-1:0];
      end
   end

   // Binary search midpoint; lo and hi stay put between issue and compare
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IB:1];
   assign rd_addr = mid;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      rnd_in        = rnd_ff;
      bit_cnt_in    = bit_cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;

      // Drop the response once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wrip_pkg::S_IDLE: begin
            if (req_valid) begin
               res_index_in  = '0;
               res_status_in = wrip_pkg::ST_OK;
               state_in      = wrip_pkg::S_DONE;
               case (wrip_pkg::op_type'(req_op))
                  wrip_pkg::OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  wrip_pkg::OP_APPEND: begin
                     if (count_ff >= CB'(wrip_pkg::MAX_ENTRIES)) begin
                        res_status_in = wrip_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        total_in = append_sum;
                        count_in = count_ff + CB'(1);
                     end
                  end
                  wrip_pkg::OP_PICK: begin
                     if (total_ff == '0 || count_ff == '0) begin
                        res_status_in = wrip_pkg::ST_ZERO_TOTAL;
                     end else begin
                        // Start the modulo; the answer lies in [0, count-1]
                        state_in   = wrip_pkg::S_DIV;
                        rem_in     = '0;
                        rnd_in     = req_random_value;
                        bit_cnt_in = DB'(RB - 1);
                        lo_in      = '0;
                        hi_in      = IB'(count_ff - CB'(1));
                     end
                  end
                  default: begin
                     // Unused code: no operation, plain OK response
                  end
               endcase
            end
         end

         wrip_pkg::S_DIV: begin
            rem_in     = rem_next;
            rnd_in     = {rnd_ff[RB-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - DB'(1);
            if (bit_cnt_ff == '0) begin
               state_in = wrip_pkg::S_SRCH_RD;
            end
         end

         wrip_pkg::S_SRCH_RD: begin
            // Read of mem[mid] is issued this cycle; it is used unless the range closed
            if (lo_ff == hi_ff) begin
               res_index_in = lo_ff;
               state_in     = wrip_pkg::S_DONE;
            end else begin
               state_in = wrip_pkg::S_SRCH_CMP;
            end
         end

         wrip_pkg::S_SRCH_CMP: begin
            // Keep the first entry whose prefix sum exceeds the target
            if (rd_data_ff > rem_ff) begin
               hi_in = mid;
            end else begin
               lo_in = mid + IB'(1);
            end
            state_in = wrip_pkg::S_SRCH_RD;
         end

         wrip_pkg::S_DONE: begin
            // Hold the result until the output register can take it
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = wrip_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = wrip_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IB-1:0]] <= append_sum;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrip_pkg::S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      rnd_ff        <= rnd_in;
      bit_cnt_ff    <= bit_cnt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(wrip_pkg::MAX_ENTRIES))
      else $error("entry count above capacity");

   // Partial remainder stays below the divisor during the modulo and search reads
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wrip_pkg::S_DIV || state_ff == wrip_pkg::S_SRCH_RD) |->
      (rem_ff < total_ff))
      else $error("modulo remainder not below total");

   // Search range stays ordered and inside the filled part of the table
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wrip_pkg::S_SRCH_RD) |->
      (lo_ff <= hi_ff && CB'(hi_ff) < count_ff))
      else $error("search range outside table");

   // Failed operations report index zero
   a_err_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != wrip_pkg::ST_OK) |-> (rsp_index_ff == '0))
      else $error("nonzero index on error status");

   // A pick only runs with entries present
   a_pick_nonempty: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == wrip_pkg::S_DIV) |-> (count_ff != '0 && total_ff != '0))
      else $error("pick started on empty table");

endmodule
